// File: rtl/u2a_pkg.sv
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, byte constants and the substitution table for the
// UTF-8 to ASCII substituter.
// ----------------------------------------------------------------------------
package u2a_pkg;

  localparam int unsigned HoldDepth = 3;

  // Lead and class masks.
  localparam logic [7:0] Mask3 = 8'he0;
  localparam logic [7:0] Lead2 = 8'hc0;
  localparam logic [7:0] Mask4 = 8'hf0;
  localparam logic [7:0] Mask5 = 8'hf8;
  localparam logic [7:0] Lead4 = 8'hf0;
  localparam logic [7:0] Lead3 = 8'he0;

  // Table bytes.
  localparam logic [7:0] ByteC2 = 8'hc2;
  localparam logic [7:0] ByteA0 = 8'ha0;
  localparam logic [7:0] ByteCb = 8'hcb;
  localparam logic [7:0] Byte96 = 8'h96;
  localparam logic [7:0] Byte97 = 8'h97;
  localparam logic [7:0] ByteE2 = 8'he2;
  localparam logic [7:0] ByteEf = 8'hef;
  localparam logic [7:0] ByteBb = 8'hbb;
  localparam logic [7:0] ByteBf = 8'hbf;

  // Replacement characters.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChNone  = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLOSE
  } state_e;

  typedef enum logic [1:0] {
    ACT_STOP,
    ACT_EMIT,
    ACT_DROP
  } act_e;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic end_line;
    logic can_emit;
    logic out_free;
  } sts_t;

  // Length of the sequence led by b: 2 or 3 for a two- or three-byte lead, 1 otherwise.
  function automatic logic [1:0] seq_need(input logic [7:0] b);
    logic [1:0] need;
    need = 2'd1;
    if ((b & Mask3) == Lead2) begin
      need = 2'd2;
    end else if ((b & Mask4) == Lead3) begin
      need = 2'd3;
    end
    return need;
  endfunction

  function automatic logic [7:0] subst2(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] s;
    s = ChNone;
    if (a == ByteC2 && b == ByteA0) begin
      s = ChSpace;
    end else if (a == ByteCb && b == Byte96) begin
      s = ChPlus;
    end else if (a == ByteCb && b == Byte97) begin
      s = ChMinus;
    end
    return s;
  endfunction

  function automatic logic [7:0] subst3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    logic [7:0] s;
    s = ChNone;
    if (a == ByteEf) begin
      if (b == ByteBb && c == ByteBf) begin
        s = ChSpace;
      end
    end else if (a == ByteE2) begin
      if (b == 8'h80) begin
        if (c >= 8'h80 && c <= 8'h8b) begin
          s = ChSpace;
        end else if (c == 8'h98 || c == 8'h99) begin
          s = ChApos;
        end else if (c == 8'h9c || c == 8'h9d) begin
          s = ChQuote;
        end else if (c == 8'haf) begin
          s = ChSpace;
        end
      end else if (b == 8'h81) begin
        if (c == 8'ha0 || c == 8'ha3) begin
          s = ChSpace;
        end else if (c == 8'ha4) begin
          s = ChPlus;
        end
      end else if (b == 8'h88 && c == 8'h92) begin
        s = ChMinus;
      end
    end
    return s;
  endfunction

endpackage

// File: rtl/u2a_dp.sv
// ----------------------------------------------------------------------------
// u2a_dp
// Datapath: holding buffer, sequence decision, pending result and
// output register.
// ----------------------------------------------------------------------------
module u2a_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u2a_pkg::cmd_t     cmd_i,
  output u2a_pkg::sts_t     sts_o,
  input  logic [7:0]        in_byte_i,
  input  logic              last_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              has_byte_o,
  output logic              last_out_o
);

  logic [7:0] buf_q [u2a_pkg::HoldDepth];
  logic [7:0] buf_d [u2a_pkg::HoldDepth];
  logic [1:0] cnt_q, cnt_d;
  logic       end_q, end_d;
  logic       pend_valid_q, pend_valid_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       has_q, has_d;
  logic       last_q, last_d;

  u2a_pkg::act_e act;
  logic [7:0]    sym;
  logic [1:0]    shift;
  logic [1:0]    need;
  logic [7:0]    s2;
  logic [7:0]    s3;
  logic          out_free;
  logic          can_emit;

  // Decide what the byte at the head of the buffer does.
  always_comb begin
    need  = u2a_pkg::seq_need(buf_q[0]);
    s2    = u2a_pkg::subst2(buf_q[0], buf_q[1]);
    s3    = u2a_pkg::subst3(buf_q[0], buf_q[1], buf_q[2]);
    act   = u2a_pkg::ACT_STOP;
    sym   = buf_q[0];
    shift = 2'd1;
    if (cnt_q == 2'd0) begin
      act = u2a_pkg::ACT_STOP;
    end else if (need != 2'd1) begin
      if (cnt_q < need) begin
        act = end_q ? u2a_pkg::ACT_DROP : u2a_pkg::ACT_STOP;
      end else if (need == 2'd2 && s2 != u2a_pkg::ChNone) begin
        act   = u2a_pkg::ACT_EMIT;
        sym   = s2;
        shift = 2'd2;
      end else if (need == 2'd3 && s3 != u2a_pkg::ChNone) begin
        act   = u2a_pkg::ACT_EMIT;
        sym   = s3;
        shift = 2'd3;
      end else begin
        act = u2a_pkg::ACT_DROP;
      end
    end else if ((buf_q[0] & u2a_pkg::Mask5) == u2a_pkg::Lead4) begin
      act = u2a_pkg::ACT_DROP;
    end else begin
      act = u2a_pkg::ACT_EMIT;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign can_emit = out_free || (end_q && !pend_valid_q);

  always_comb begin
    sts_o.act      = act;
    sts_o.end_line = end_q;
    sts_o.can_emit = can_emit;
    sts_o.out_free = out_free;
  end

  always_comb begin
    for (int i = 0; i < u2a_pkg::HoldDepth; i++) begin
      buf_d[i] = buf_q[i];
    end
    cnt_d        = cnt_q;
    end_d        = end_q;
    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    has_d        = has_q;
    last_d       = last_q;

    if (cmd_i.load) begin
      buf_d[cnt_q] = in_byte_i;
      cnt_d        = cnt_q + 2'd1;
      end_d        = last_in_i;
    end

    if (cmd_i.step) begin
      unique case (shift)
        2'd1: begin
          buf_d[0] = buf_q[1];
          buf_d[1] = buf_q[2];
        end
        2'd2: begin
          buf_d[0] = buf_q[2];
        end
        default: begin
        end
      endcase
      cnt_d = cnt_q - shift;
      if (act == u2a_pkg::ACT_EMIT) begin
        if (!end_q) begin
          // Bytes of an earlier word are never the last of the line.
          out_valid_d = 1'b1;
          out_byte_d  = sym;
          has_d       = 1'b1;
          last_d      = 1'b0;
        end else begin
          // The older pending byte moves out; the new one waits in its place.
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_byte_d  = pend_byte_q;
            has_d       = 1'b1;
            last_d      = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_byte_d  = sym;
        end
      end
    end

    if (cmd_i.flush) begin
      out_valid_d  = 1'b1;
      out_byte_d   = pend_valid_q ? pend_byte_q : u2a_pkg::ChNone;
      has_d        = pend_valid_q;
      last_d       = 1'b1;
      pend_valid_d = 1'b0;
      end_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= 2'd0;
      end_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      end_q        <= end_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < u2a_pkg::HoldDepth; i++) begin
      buf_q[i] <= buf_d[i];
    end
    pend_byte_q <= pend_byte_d;
    out_byte_q  <= out_byte_d;
    has_q       <= has_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign has_byte_o  = has_q;
  assign last_out_o  = last_q;

  // A new byte always finds a free slot in the buffer.
  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> cnt_q != 2'd3)
    else $error("byte loaded into a full buffer");

  // The line closes only once every held byte is resolved and the output is free.
  a_flush_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |-> (cnt_q == 2'd0 && out_free))
    else $error("line closed with bytes held or output busy");

  // An emitting step never overwrites a pending byte that cannot move out.
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && act == u2a_pkg::ACT_EMIT) |-> can_emit)
    else $error("pending byte lost");

endmodule

// File: rtl/u2a_ctrl.sv
// ----------------------------------------------------------------------------
// u2a_ctrl
// Controller: sequences byte intake, buffer resolution and line close.
// ----------------------------------------------------------------------------
module u2a_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  u2a_pkg::sts_t sts_i,
  output u2a_pkg::cmd_t cmd_o
);

  u2a_pkg::state_e state_q, state_d;
  logic            take;

  assign take = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      u2a_pkg::ST_IDLE: begin
        if (take) begin
          state_d = u2a_pkg::ST_SCAN;
        end
      end
      u2a_pkg::ST_SCAN: begin
        if (sts_i.act == u2a_pkg::ACT_STOP) begin
          if (sts_i.end_line) begin
            state_d = u2a_pkg::ST_CLOSE;
          end else if (!take) begin
            state_d = u2a_pkg::ST_IDLE;
          end
        end
      end
      u2a_pkg::ST_CLOSE: begin
        if (sts_i.out_free) begin
          state_d = u2a_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = u2a_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.step  = 1'b0;
    cmd_o.flush = 1'b0;
    unique case (state_q)
      u2a_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      u2a_pkg::ST_SCAN: begin
        unique case (sts_i.act)
          u2a_pkg::ACT_EMIT: cmd_o.step = sts_i.can_emit;
          u2a_pkg::ACT_DROP: cmd_o.step = 1'b1;
          default: begin
            // Buffer settled: take the next word straight away mid-line.
            in_ready_o = !sts_i.end_line;
            cmd_o.load = in_valid_i && !sts_i.end_line;
          end
        endcase
      end
      u2a_pkg::ST_CLOSE: begin
        cmd_o.flush = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= u2a_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/utf8_to_ascii_substituter.sv
// ----------------------------------------------------------------------------
// utf8_to_ascii_substituter
// Converts a line of raw bytes into ASCII, replacing a few common UTF-8
// punctuation sequences with plain characters.
// ----------------------------------------------------------------------------
// Each input word is one byte of a line, with last_in_i set on the final
// byte. One word is taken, then the held buffer is resolved one decision per
// cycle (emit one byte, or drop one lead) while the output can take the
// byte; a stalled output holds an emitting step. No new word is taken until
// the buffer has settled.
// Bytes released by an earlier word of a line go straight to the output
// register with last_out_o low. Bytes released by the final word wait in a
// pending stage until the next result or the line close is known, because
// only then can their last_out_o flag be decided. To close a line, the
// controller first sees that the buffer has settled and then sends the
// last word. When the final word of a line yields no bytes, the line closes
// with a single empty word (has_byte_o low, last_out_o high). The output
// register lets the input side keep working while a finished word waits to
// be taken.
module utf8_to_ascii_substituter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       last_out_o
);

  u2a_pkg::cmd_t cmd;
  u2a_pkg::sts_t sts;

  // Controller: decides when to take a word, step the buffer or close the line.
  u2a_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: holds up to three bytes and judges the one at the head.
  u2a_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_byte_i   (in_byte_i),
    .last_in_i   (last_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .last_out_o  (last_out_o)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_to_ascii_substituter. Lines of raw bytes go in
// through a valid/ready driver; an internal byte translator predicts the
// ASCII words of each line, and a monitor checks every output word in order.
// ----------------------------------------------------------------------------
module tb;

  // One raw input word plus the bench's own bookkeeping for it.
  typedef struct {
    logic [7:0] data;
    logic       last;
    int unsigned phase;
    logic       drain;
  } raw_word_t;

  // One output word as the block should produce it.
  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       last;
  } ascii_word_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       out_last;

  // Raw words still to be offered, and ASCII words still to be seen.
  raw_word_t   raw_q[$];
  ascii_word_t ascii_q[$];
  logic [7:0]  line_q[$];

  // Translator state: bytes of an unfinished sequence, always led by a lead.
  logic [7:0]  held [2];
  int unsigned held_n = 0;

  int unsigned errors = 0;
  int unsigned cur_phase = 0;

  // Idle percentages per phase: the receiver is lazy first, then the sender,
  // and in the last phase both sides run flat out.
  int unsigned send_idle_pct [3] = '{18, 62, 0};
  int unsigned recv_idle_pct [3] = '{62, 18, 0};

  // Number of raw words that make up the directed lines.
  localparam int unsigned DirectedWords = 28;
  localparam int unsigned RandomWords   = 300;

  utf8_to_ascii_substituter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_byte_i  (in_byte),
    .last_in_i  (in_last),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_byte_o (out_byte),
    .has_byte_o (has_byte),
    .last_out_o (out_last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Translator
  // ---------------------------------------------------------------------------

  // Bytes in the sequence that b starts: 2 or 3 for a lead we wait on, else 1.
  // Four-byte leads count as 1 here; they are dropped on their own.
  function automatic int unsigned lead_len(input logic [7:0] b);
    int unsigned len;
    casez (b)
      8'b110?_????: len = 2;
      8'b1110_????: len = 3;
      default:      len = 1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] pair_char(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] ch;
    case ({a, b})
      16'hc2a0: ch = u2a_pkg::ChSpace;  // no-break space
      16'hcb96: ch = u2a_pkg::ChPlus;   // modifier plus
      16'hcb97: ch = u2a_pkg::ChMinus;  // modifier minus
      default:  ch = u2a_pkg::ChNone;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] triple_char(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
    logic [7:0] ch;
    ch = u2a_pkg::ChNone;
    case ({a, b})
      16'hefbb: if (c == 8'hbf) ch = u2a_pkg::ChSpace;  // byte order mark
      16'he280: begin
        // General punctuation block: spaces, curly quotes, narrow space.
        if (c >= 8'h80 && c <= 8'h8b) ch = u2a_pkg::ChSpace;
        else if (c == 8'haf) ch = u2a_pkg::ChSpace;
        else if (c == 8'h98 || c == 8'h99) ch = u2a_pkg::ChApos;
        else if (c == 8'h9c || c == 8'h9d) ch = u2a_pkg::ChQuote;
      end
      16'he281: begin
        if (c == 8'ha0 || c == 8'ha3) ch = u2a_pkg::ChSpace;
        else if (c == 8'ha4) ch = u2a_pkg::ChPlus;
      end
      16'he288: if (c == 8'h92) ch = u2a_pkg::ChMinus;  // math minus
      default: ;
    endcase
    return ch;
  endfunction

  // Feeds one raw byte to the translator and queues the ASCII words it yields.
  // Held bytes come first; each position is either a finished sequence that
  // is replaced, a lead that is dropped (no match, cut by line end, or a
  // four-byte lead), a plain byte that passes, or an unfinished sequence that
  // stays held for the next word.
  task automatic translate_byte(input logic [7:0] b, input logic fin);
    logic [7:0]  pool [3];
    ascii_word_t res [3];
    int unsigned n;
    int unsigned pos;
    int unsigned need;
    int unsigned cnt;
    logic [7:0]  ch;
    for (int unsigned i = 0; i < held_n; i++) pool[i] = held[i];
    pool[held_n] = b;
    n = held_n + 1;
    pos = 0;
    cnt = 0;
    while (pos < n) begin
      need = lead_len(pool[pos]);
      if (need > 1) begin
        if (n - pos < need) begin
          if (!fin) break;
          pos++;  // the line ended inside the sequence: drop the lead
        end else begin
          if (need == 2) ch = pair_char(pool[pos], pool[pos + 1]);
          else ch = triple_char(pool[pos], pool[pos + 1], pool[pos + 2]);
          if (ch != u2a_pkg::ChNone) begin
            res[cnt] = '{ch, 1'b1, 1'b0};
            cnt++;
            pos += need;
          end else begin
            pos++;  // no match: only the lead goes, the rest is judged again
          end
        end
      end else if (pool[pos][7:3] == 5'b11110) begin
        pos++;
      end else begin
        res[cnt] = '{pool[pos], 1'b1, 1'b0};
        cnt++;
        pos++;
      end
    end
    held_n = 0;
    while (pos < n) begin
      held[held_n] = pool[pos];
      held_n++;
      pos++;
    end
    // The end of a line is marked on its last word, or on an empty word
    // when this step produced nothing.
    if (fin) begin
      if (cnt == 0) begin
        res[0] = '{8'h00, 1'b0, 1'b1};
        cnt = 1;
      end else begin
        res[cnt - 1].last = 1'b1;
      end
    end
    for (int unsigned i = 0; i < cnt; i++) ascii_q = {ascii_q, res[i]};
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  // Moves the bytes gathered in line_q into the raw word queue as one line.
  task automatic flush_line(input int unsigned phase, input logic drain);
    raw_word_t w;
    for (int unsigned i = 0; i < line_q.size(); i++) begin
      w.data  = line_q[i];
      w.last  = (i == line_q.size() - 1);
      w.phase = phase;
      w.drain = drain && (i == 0);
      raw_q = {raw_q, w};
    end
    line_q.delete();
  endtask

  // Appends one sequence taken at random from the substitution table.
  task automatic add_table_seq();
    case ($urandom_range(12))
      0:  line_q = {line_q, 8'hc2, 8'ha0};
      1:  line_q = {line_q, 8'hcb, 8'h96};
      2:  line_q = {line_q, 8'hcb, 8'h97};
      3:  line_q = {line_q, 8'he2, 8'h80, 8'(8'h80 + $urandom_range(11))};
      4:  line_q = {line_q, 8'he2, 8'h80, 8'(8'h98 + $urandom_range(1))};
      5:  line_q = {line_q, 8'he2, 8'h80, 8'(8'h9c + $urandom_range(1))};
      6:  line_q = {line_q, 8'he2, 8'h80, 8'haf};
      7:  line_q = {line_q, 8'he2, 8'h81, 8'ha0};
      8:  line_q = {line_q, 8'he2, 8'h81, 8'ha3};
      9:  line_q = {line_q, 8'he2, 8'h81, 8'ha4};
      10: line_q = {line_q, 8'he2, 8'h88, 8'h92};
      11: line_q = {line_q, 8'hef, 8'hbb, 8'hbf};
      default: line_q = {line_q, 8'hc2, 8'ha0};
    endcase
  endtask

  initial begin
    int unsigned phase;
    int unsigned prev_phase;
    int unsigned r;
    int unsigned tokens;
    logic [7:0]  lead;

    // Directed lines. Pass-through extremes, a stray continuation, an F8
    // byte and a dropped four-byte lead.
    line_q = {8'h00, 8'h7f, 8'hff, 8'h80, 8'hf8, 8'hf0, 8'h41};
    flush_line(0, 1'b0);
    // All two-byte table entries.
    line_q = {8'hc2, 8'ha0, 8'hcb, 8'h96, 8'hcb, 8'h97};
    flush_line(0, 1'b0);
    // A curly quote, an unmatched two-byte lead, and a sequence cut by the
    // end of the line whose continuation byte is then passed on its own.
    line_q = {8'he2, 8'h80, 8'h9c, 8'hc3, 8'h41, 8'he2, 8'h80};
    flush_line(0, 1'b0);
    // An unmatched three-byte lead that releases two bytes in one step,
    // then the byte order mark.
    line_q = {8'he2, 8'h41, 8'h42, 8'hef, 8'hbb, 8'hbf};
    flush_line(0, 1'b0);
    // Lines that yield nothing close with an empty word.
    line_q = {8'hf0};
    flush_line(0, 1'b0);
    line_q = {8'hc2};
    flush_line(0, 1'b0);

    // Random lines. Two in five tokens are well-formed table sequences; the rest
    // are plain text, arbitrary bytes, leads with random tails and
    // near misses of the table.
    prev_phase = 0;
    while (raw_q.size() < DirectedWords + RandomWords) begin
      phase = (raw_q.size() - DirectedWords) * 3 / RandomWords;
      if (phase > 2) phase = 2;
      tokens = $urandom_range(1, 5);
      repeat (tokens) begin
        r = $urandom_range(99);
        if (r < 40) begin
          add_table_seq();
        end else if (r < 62) begin
          line_q = {line_q, 8'($urandom_range(127))};
        end else if (r < 74) begin
          line_q = {line_q, 8'($urandom)};
        end else if (r < 86) begin
          case ($urandom_range(2))
            0:       lead = 8'hc0 | 8'($urandom_range(31));
            1:       lead = 8'he0 | 8'($urandom_range(15));
            default: lead = 8'hf0 | 8'($urandom_range(7));
          endcase
          line_q = {line_q, lead};
          repeat ((lead[5] ? (lead[4] ? 3 : 2) : 1))
            line_q = {line_q, 8'h80 | 8'($urandom_range(63))};
        end else if (r < 94) begin
          add_table_seq();
          line_q[line_q.size() - 1] = 8'h80 | 8'($urandom_range(63));
        end else begin
          add_table_seq();
          void'(line_q.pop_back());
        end
      end
      // The first line of each new phase waits until the block has drained.
      flush_line(phase, phase != prev_phase);
      prev_phase = phase;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Run until every raw word is taken and every ASCII word has come back,
    // then give the block a little longer to show any stray output.
    while (raw_q.size() != 0 || in_valid || ascii_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (ascii_q.size() != 0) begin
      $display("%0t: %0d expected word(s) never arrived", $time, ascii_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers raw words, holding valid and payload until accepted.
  // ---------------------------------------------------------------------------
  logic      slot_free;
  raw_word_t next_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_byte  <= 8'h00;
      in_last  <= 1'b0;
    end else begin
      slot_free = !in_valid || in_ready;
      if (in_valid && in_ready) begin
        translate_byte(in_byte, in_last);
      end
      if (slot_free) begin
        // A word flagged to drain is held back until the output side has
        // delivered everything predicted so far.
        if (raw_q.size() != 0 && !(raw_q[0].drain && ascii_q.size() != 0) &&
            $urandom_range(99) >= send_idle_pct[raw_q[0].phase]) begin
          next_word = raw_q.pop_front();
          cur_phase = next_word.phase;
          in_valid <= 1'b1;
          in_byte  <= next_word.data;
          in_last  <= next_word.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stalls at random and checks each accepted word in order.
  // ---------------------------------------------------------------------------
  ascii_word_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (ascii_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, got byte %02h has %0b last %0b",
                   $time, out_byte, has_byte, out_last);
          errors++;
        end else begin
          want = ascii_q.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte mismatch: expected %02h, got %02h",
                     $time, want.data, out_byte);
            errors++;
          end
          if (has_byte !== want.has) begin
            $display("%0t: has_byte mismatch: expected %0b, got %0b",
                     $time, want.has, has_byte);
            errors++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last_out mismatch: expected %0b, got %0b",
                     $time, want.last, out_last);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct[cur_phase]);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/u2a_pkg.sv
rtl/u2a_dp.sv
rtl/u2a_ctrl.sv
rtl/utf8_to_ascii_substituter.sv
tb/tb.sv
